FILE: rtl/bdlp_pkg.sv
// Shared types, register indexes and constants for the button debounce block.
// No dependencies; every other file imports this package.
package bdlp_pkg;

  localparam int unsigned TickW = 32;
  localparam int unsigned CfgW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned VolW = 7;
  localparam int unsigned PctW = 7;
  localparam int unsigned StepW = 2;

  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_HOLD = 2'd1;

  localparam logic [CfgW-1:0] DEBOUNCE_RESET = 16'd80;
  localparam logic [CfgW-1:0] HOLD_RESET = 16'd1400;

  localparam logic [VolW-1:0] VOL_STEP = 7'd5;
  localparam logic [VolW-1:0] VOL_MAX = 7'd100;
  localparam logic [VolW-1:0] VOL_RESET = 7'd70;
  localparam logic [StepW-1:0] WAKE_STEP = 2'd3;
  localparam logic [StepW-1:0] DARK_STEP = 2'd0;

  // Pin levels are active low: 1 means released.
  localparam logic [2:0] LEVELS_RELEASED = 3'b111;

  typedef struct packed {
    logic [TickW-1:0] now_ticks;
    logic             plus_level;
    logic             power_level;
    logic             minus_level;
  } in_t;

  typedef struct packed {
    logic            volume_up_event;
    logic            volume_down_event;
    logic            power_off_event;
    logic            brightness_event;
    logic [VolW-1:0] volume_percent;
    logic [PctW-1:0] brightness_percent;
    logic            display_sleeping;
  } out_t;

  // Power button events found for one sample.
  typedef struct packed {
    logic power_off;
    logic bright_cycle;
  } pwr_ev_t;

  function automatic logic [PctW-1:0] bright_pct(input logic [StepW-1:0] step);
    logic [PctW-1:0] pct;
    case (step)
      2'd0:    pct = 7'd0;
      2'd1:    pct = 7'd20;
      2'd2:    pct = 7'd50;
      default: pct = 7'd80;
    endcase
    return pct;
  endfunction

endpackage

FILE: rtl/bdlp_key.sv
// Falling-edge press detector with a lockout window, for the plus or minus button.
// Depends on bdlp_pkg.
module bdlp_key (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        upd,
  input  logic [bdlp_pkg::TickW-1:0]  now_ticks,
  input  logic                        level,
  input  logic                        last_level,
  input  logic [bdlp_pkg::CfgW-1:0]   debounce_ticks,
  output logic                        press
);
  import bdlp_pkg::*;

  logic [TickW-1:0] lockout_until;

  // Plain unsigned compare: the lockout end does not wrap-track the counter.
  assign press = last_level & ~level & (now_ticks >= lockout_until);

  always_ff @(posedge clk) begin
    if (rst) begin
      lockout_until <= '0;
    end else if (upd && press) begin
      lockout_until <= now_ticks + {{(TickW-CfgW){1'b0}}, debounce_ticks};
    end
  end

endmodule

FILE: rtl/bdlp_power.sv
// Power button tracker: hold timing for power-off, short release for brightness.
// Depends on bdlp_pkg.
module bdlp_power (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        upd,
  input  logic [bdlp_pkg::TickW-1:0]  now_ticks,
  input  logic                        level,
  input  logic                        last_level,
  input  logic [bdlp_pkg::CfgW-1:0]   debounce_ticks,
  input  logic [bdlp_pkg::CfgW-1:0]   hold_ticks,
  output bdlp_pkg::pwr_ev_t           ev
);
  import bdlp_pkg::*;

  logic [TickW-1:0] press_start;
  logic [TickW-1:0] lockout_until;
  logic             hold_handled;

  logic             pressed_edge;
  logic             released_ok;
  logic [TickW-1:0] start_next;
  logic             handled_eff;
  logic [TickW-1:0] held;

  assign pressed_edge = last_level & ~level;
  assign start_next   = pressed_edge ? now_ticks : press_start;
  assign handled_eff  = pressed_edge ? 1'b0 : hold_handled;
  assign held         = now_ticks - start_next;
  assign released_ok  = ~last_level & level & (now_ticks >= lockout_until);

  always_comb begin
    ev.power_off    = ~level & ~handled_eff & (held >= {{(TickW-CfgW){1'b0}}, hold_ticks});
    ev.bright_cycle = released_ok & ~handled_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_start   <= '0;
      lockout_until <= '0;
      hold_handled  <= 1'b0;
    end else if (upd) begin
      press_start  <= start_next;
      hold_handled <= handled_eff | ev.power_off;
      // A release restarts the lockout even after a handled hold.
      if (ev.power_off || released_ok) begin
        lockout_until <= now_ticks + {{(TickW-CfgW){1'b0}}, debounce_ticks};
      end
    end
  end

endmodule

FILE: rtl/button_debounce_long_press_control.sv
// Button debounce with long press: volume up/down and power/brightness control.
// Input side takes one poll word per handshake: a 32-bit tick stamp and three
// active-low pin levels (plus, power, minus). Output side gives one word per
// input word: four event flags, the volume (0..100 in steps of 5), the display
// brightness (0/20/50/80) and a sleeping flag.
// Both sides use valid/ready. A word sits in an input register, the press
// logic runs against the button state, and the result lands in an output
// register that drives out_valid.
// Throughput is one word per cycle while the output is not stalled; the button
// state is read and written as the word moves into the output register.
// When the receiver stalls, the output word holds and the input register
// still takes one more word; in_ready drops only when both are full.
// Config writes (cfg_wen, cfg_index, cfg_wdata) are registered: index 0 is
// the debounce lockout, index 1 the power hold time; other indexes are ignored.
// Synchronous reset empties both registers, sets volume 70, brightness 80,
// all buttons released, lockouts and press start to zero, and restores the
// default lockout (80) and hold (1400) times.
// Depends on bdlp_pkg, bdlp_key and bdlp_power.
module button_debounce_long_press_control (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bdlp_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bdlp_pkg::out_t                out_data,
  input  logic                          cfg_wen,
  input  logic [bdlp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [bdlp_pkg::CfgW-1:0]     cfg_wdata
);
  import bdlp_pkg::*;

  logic [CfgW-1:0]  debounce_ticks;
  logic [CfgW-1:0]  hold_ticks;

  logic             s1_valid;
  in_t              s1_data;
  logic             adv;
  logic             fire;

  logic [2:0]       last_levels;
  logic [VolW-1:0]  volume_level;
  logic [StepW-1:0] brightness_step;
  logic             sleeping_flag;

  logic             ev_up;
  logic             ev_down;
  pwr_ev_t          pwr_ev;

  logic [VolW:0]    vol_sum;
  logic [VolW-1:0]  vol_mid;
  logic [VolW-1:0]  volume_next;
  logic [StepW-1:0] step_a;
  logic [StepW-1:0] step_b;
  logic [StepW-1:0] step_next;
  logic             sleep_a;
  logic             sleep_b;
  logic             sleeping_next;
  out_t             res;

  assign adv      = ~out_valid | out_ready;
  assign fire     = s1_valid & adv;
  assign in_ready = ~s1_valid | adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_RESET;
      hold_ticks     <= HOLD_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_DEBOUNCE: debounce_ticks <= cfg_wdata;
        REG_HOLD:     hold_ticks     <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  bdlp_key u_plus (
    .clk            (clk),
    .rst            (rst),
    .upd            (fire),
    .now_ticks      (s1_data.now_ticks),
    .level          (s1_data.plus_level),
    .last_level     (last_levels[0]),
    .debounce_ticks (debounce_ticks),
    .press          (ev_up)
  );

  bdlp_power u_power (
    .clk            (clk),
    .rst            (rst),
    .upd            (fire),
    .now_ticks      (s1_data.now_ticks),
    .level          (s1_data.power_level),
    .last_level     (last_levels[1]),
    .debounce_ticks (debounce_ticks),
    .hold_ticks     (hold_ticks),
    .ev             (pwr_ev)
  );

  bdlp_key u_minus (
    .clk            (clk),
    .rst            (rst),
    .upd            (fire),
    .now_ticks      (s1_data.now_ticks),
    .level          (s1_data.minus_level),
    .last_level     (last_levels[2]),
    .debounce_ticks (debounce_ticks),
    .press          (ev_down)
  );

  // Apply effects in order: plus, power, minus.
  always_comb begin
    vol_sum = {1'b0, volume_level} + {1'b0, VOL_STEP};
    vol_mid = volume_level;
    if (ev_up) begin
      vol_mid = (vol_sum > {1'b0, VOL_MAX}) ? VOL_MAX : vol_sum[VolW-1:0];
    end
    volume_next = vol_mid;
    if (ev_down) begin
      volume_next = (vol_mid < VOL_STEP) ? '0 : vol_mid - VOL_STEP;
    end

    // Volume press wakes a sleeping display.
    step_a  = brightness_step;
    sleep_a = sleeping_flag;
    if (ev_up && sleeping_flag) begin
      step_a  = WAKE_STEP;
      sleep_a = 1'b0;
    end
    step_b  = step_a;
    sleep_b = sleep_a;
    if (pwr_ev.bright_cycle) begin
      step_b  = step_a + 2'd1;
      sleep_b = (step_b == DARK_STEP);
    end
    step_next     = step_b;
    sleeping_next = sleep_b;
    if (ev_down && sleep_b) begin
      step_next     = WAKE_STEP;
      sleeping_next = 1'b0;
    end

    res.volume_up_event    = ev_up;
    res.volume_down_event  = ev_down;
    res.power_off_event    = pwr_ev.power_off;
    res.brightness_event   = pwr_ev.bright_cycle;
    res.volume_percent     = volume_next;
    res.brightness_percent = bright_pct(step_next);
    res.display_sleeping   = sleeping_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_levels     <= LEVELS_RELEASED;
      volume_level    <= VOL_RESET;
      brightness_step <= WAKE_STEP;
      sleeping_flag   <= 1'b0;
    end else if (fire) begin
      last_levels     <= {s1_data.minus_level, s1_data.power_level, s1_data.plus_level};
      volume_level    <= volume_next;
      brightness_step <= step_next;
      sleeping_flag   <= sleeping_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= res;
    end
  end

endmodule

FILE: rtl/bdlp_checker.sv
// Port-level checks for the button debounce block, bound to the top level.
// Depends on bdlp_pkg.
module bdlp_checker (
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_ready,
  input bdlp_pkg::out_t  out_data
);
  import bdlp_pkg::*;

  // Hold a stalled output word.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  a_vol_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.volume_percent <= VOL_MAX)
    else $error("volume above maximum");

  a_sleep_dark: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.display_sleeping == (out_data.brightness_percent == 7'd0))
    else $error("sleeping flag disagrees with brightness");

  // One power level cannot be both a hold and a release.
  a_pwr_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.power_off_event && out_data.brightness_event))
    else $error("power-off and brightness events together");

endmodule

bind button_debounce_long_press_control bdlp_checker u_bdlp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
